FILE: src/cpg_pkg.sv
// Package for the card PIN/PUK guard: item structs, command kinds, phase codes,
// status codes and sizes shared by front, queue, back and top level.
// No dependencies.
package cpg_pkg;

  // PIN and PUK sizes in bytes
  localparam int PIN_BYTES = 4;
  localparam int PUK_BYTES = 8;
  localparam int PIN_W = 8 * PIN_BYTES;
  localparam int PUK_W = 8 * PUK_BYTES;
  localparam int PAY_W = 64;

  // command header codes
  localparam logic [7:0] CLASS_CARD  = 8'hA0;
  localparam logic [7:0] INS_INSTALL = 8'h00;
  localparam logic [7:0] INS_VERIFY  = 8'h20;
  localparam logic [7:0] INS_CHANGE  = 8'h24;
  localparam logic [7:0] INS_UNBLOCK = 8'h2C;

  // status bytes
  localparam logic [7:0] ST_OK        = 8'h90;
  localparam logic [7:0] ST_SECURITY  = 8'h98;
  localparam logic [7:0] ST_LENGTH    = 8'h6C;
  localparam logic [7:0] ST_REFUSED   = 8'h6D;
  localparam logic [7:0] ST_BAD_CLASS = 8'h6E;
  localparam logic [7:0] SW2_TRIES    = 8'h40;
  localparam logic [7:0] SW2_BAD_OLD  = 8'h4F;
  localparam logic [7:0] SW2_BLOCKED  = 8'h50;
  localparam logic [7:0] SW2_NONE     = 8'h00;

  // expected lengths
  localparam logic [7:0] LEN_PUK    = 8'(PUK_BYTES);
  localparam logic [7:0] LEN_PIN    = 8'(PIN_BYTES);
  localparam logic [7:0] LEN_CHANGE = 8'(2 * PIN_BYTES);

  localparam logic [3:0] TRIES_RESET = 4'd3;

  typedef enum logic [1:0] {
    PHASE_BLANK   = 2'd0,
    PHASE_PIN     = 2'd1,
    PHASE_BLOCKED = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_BAD_CLASS = 3'd0,
    KIND_UNKNOWN   = 3'd1,
    KIND_INSTALL   = 3'd2,
    KIND_VERIFY    = 3'd3,
    KIND_CHANGE    = 3'd4,
    KIND_UNBLOCK   = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0]       class_byte;
    logic [7:0]       instruction;
    logic [7:0]       length;
    logic [PAY_W-1:0] payload;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] status_one;
    logic [7:0] status_two;
    logic       acknowledged;
  } rsp_item_t;

  // classified command as it sits in the queue
  typedef struct packed {
    cmd_kind_t        kind;
    logic             len_ok;
    logic [PAY_W-1:0] payload;
  } cmd_t;

endpackage

FILE: src/cpg_front.sv
// Front end of the card PIN/PUK guard: takes command items and classifies
// class, instruction and length into a queue entry. Uses cpg_pkg.
module cpg_front import cpg_pkg::*; (
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      q_wr_valid,
  input  logic      q_wr_ready,
  output cmd_t      q_wr_data
);

  assign cmd_ready  = q_wr_ready;
  assign q_wr_valid = cmd_valid;

  // decode header into kind and length check
  always_comb begin
    q_wr_data.payload = cmd.payload;
    q_wr_data.kind    = KIND_UNKNOWN;
    q_wr_data.len_ok  = 1'b0;
    if (cmd.class_byte != CLASS_CARD) begin
      q_wr_data.kind = KIND_BAD_CLASS;
    end else begin
      case (cmd.instruction)
        INS_INSTALL: begin
          q_wr_data.kind   = KIND_INSTALL;
          q_wr_data.len_ok = (cmd.length == LEN_PUK);
        end
        INS_VERIFY: begin
          q_wr_data.kind   = KIND_VERIFY;
          q_wr_data.len_ok = (cmd.length == LEN_PIN);
        end
        INS_CHANGE: begin
          q_wr_data.kind   = KIND_CHANGE;
          q_wr_data.len_ok = (cmd.length == LEN_CHANGE);
        end
        INS_UNBLOCK: begin
          q_wr_data.kind   = KIND_UNBLOCK;
          q_wr_data.len_ok = (cmd.length == LEN_PUK);
        end
        default: begin
          q_wr_data.kind = KIND_UNKNOWN;
        end
      endcase
    end
  end

endmodule

FILE: src/cpg_queue.sv
// Two-entry queue of classified commands between front and back end.
// Uses cpg_pkg for the entry type.
module cpg_queue import cpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/cpg_back.sv
// Back end of the card PIN/PUK guard: holds card state, carries out queued
// commands and registers the status item. Uses cpg_pkg.
module cpg_back import cpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_data,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_item_t  rsp
);

  logic [3:0]       retry_limit;
  phase_t           phase;
  phase_t           phase_next;
  logic [3:0]       tries_left;
  logic [3:0]       tries_left_next;
  logic [PIN_W-1:0] stored_pin;
  logic [PIN_W-1:0] stored_pin_next;
  logic [PUK_W-1:0] stored_puk;
  logic [PUK_W-1:0] stored_puk_next;
  logic             verified;
  logic             verified_next;
  rsp_item_t        rsp_next;

  logic             go_pin;
  logic             go_blocked;
  logic             fire;
  logic [PIN_W-1:0] pin_old;
  logic [PIN_W-1:0] pin_new;
  logic [PUK_W-1:0] puk_in;
  logic [3:0]       left;

  assign q_ready = !rsp_valid || rsp_ready;
  assign fire    = q_valid && q_ready;
  assign pin_old = q_data.payload[PAY_W-1 -: PIN_W];
  assign pin_new = q_data.payload[PAY_W-1-PIN_W -: PIN_W];
  assign puk_in  = q_data.payload[PAY_W-1 -: PUK_W];
  assign left    = (tries_left != 4'd0) ? tries_left - 4'd1 : 4'd0;

  // command decision: status, data updates and phase moves
  always_comb begin
    rsp_next        = '{status_one: ST_REFUSED, status_two: SW2_NONE, acknowledged: 1'b0};
    tries_left_next = tries_left;
    stored_pin_next = stored_pin;
    stored_puk_next = stored_puk;
    verified_next   = verified;
    go_pin          = 1'b0;
    go_blocked      = 1'b0;
    case (q_data.kind)
      KIND_BAD_CLASS: begin
        rsp_next.status_one = ST_BAD_CLASS;
      end
      KIND_INSTALL: begin
        if (phase != PHASE_BLANK) begin
          rsp_next.status_one = ST_REFUSED;
        end else if (!q_data.len_ok) begin
          rsp_next.status_one = ST_LENGTH;
          rsp_next.status_two = LEN_PUK;
        end else begin
          rsp_next.acknowledged = 1'b1;
          rsp_next.status_one   = ST_OK;
          stored_puk_next       = puk_in;
          stored_pin_next       = '0;
          go_pin                = 1'b1;
        end
      end
      KIND_VERIFY: begin
        if (phase != PHASE_PIN || verified) begin
          rsp_next.status_one = ST_REFUSED;
        end else if (!q_data.len_ok) begin
          rsp_next.status_one = ST_LENGTH;
          rsp_next.status_two = LEN_PIN;
        end else begin
          rsp_next.acknowledged = 1'b1;
          if (pin_old != stored_pin) begin
            tries_left_next     = left;
            rsp_next.status_one = ST_SECURITY;
            if (left == 4'd0) begin
              rsp_next.status_two = SW2_BLOCKED;
              go_blocked          = 1'b1;
            end else begin
              rsp_next.status_two = SW2_TRIES | {4'd0, left};
            end
          end else begin
            tries_left_next     = retry_limit;
            verified_next       = 1'b1;
            rsp_next.status_one = ST_OK;
          end
        end
      end
      KIND_CHANGE: begin
        if (!verified || phase == PHASE_BLOCKED) begin
          rsp_next.status_one = ST_REFUSED;
        end else if (!q_data.len_ok) begin
          rsp_next.status_one = ST_LENGTH;
          rsp_next.status_two = LEN_CHANGE;
        end else begin
          rsp_next.acknowledged = 1'b1;
          if (pin_old != stored_pin) begin
            rsp_next.status_one = ST_SECURITY;
            rsp_next.status_two = SW2_BAD_OLD;
          end else begin
            stored_pin_next     = pin_new;
            rsp_next.status_one = ST_OK;
            go_pin              = 1'b1;
          end
        end
      end
      KIND_UNBLOCK: begin
        if (phase != PHASE_BLOCKED) begin
          rsp_next.status_one = ST_REFUSED;
        end else if (!q_data.len_ok) begin
          rsp_next.status_one = ST_LENGTH;
          rsp_next.status_two = LEN_PUK;
        end else begin
          rsp_next.acknowledged = 1'b1;
          if (puk_in != stored_puk) begin
            rsp_next.status_one = ST_SECURITY;
            rsp_next.status_two = SW2_BLOCKED;
          end else begin
            tries_left_next     = retry_limit;
            stored_pin_next     = '0;
            rsp_next.status_one = ST_OK;
            go_pin              = 1'b1;
          end
        end
      end
      default: begin
        rsp_next.status_one = ST_REFUSED;
      end
    endcase
  end

  // card phase next state
  always_comb begin
    phase_next = phase;
    if (go_blocked) begin
      phase_next = PHASE_BLOCKED;
    end else if (go_pin) begin
      phase_next = PHASE_PIN;
    end
  end

  // card state and retry limit
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= TRIES_RESET;
      phase       <= PHASE_BLANK;
      tries_left  <= TRIES_RESET;
      stored_pin  <= '0;
      stored_puk  <= '0;
      verified    <= 1'b0;
    end else begin
      if (cfg_we) begin
        retry_limit <= cfg_data;
      end
      if (fire) begin
        phase      <= phase_next;
        tries_left <= tries_left_next;
        stored_pin <= stored_pin_next;
        stored_puk <= stored_puk_next;
        verified   <= verified_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: src/card_pin_puk_guard_unit.sv
// Card PIN/PUK guard: one status item per command item.
// A command passes from accept through the queue, then the output register, to status valid.
// Throughput: one command per cycle while the status side takes items; the back end's combinational decision sets this.
// Two-entry queue decouples front and back; output register holds one status item.
// Reset (synchronous, active high): blank phase, 3 tries, PIN/PUK zero,
// not verified, retry limit 3, queue and output empty.
module card_pin_puk_guard_unit import cpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_item_t  cmd,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_item_t  rsp,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  logic q_wr_valid;
  logic q_wr_ready;
  cmd_t q_wr_data;
  logic q_rd_valid;
  logic q_rd_ready;
  cmd_t q_rd_data;

  cpg_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_data  (q_wr_data)
  );

  cpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  cpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_rd_valid),
    .q_ready   (q_rd_ready),
    .q_data    (q_rd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // a command taken by the back end shows up as a status item next cycle
  a_pop_to_rsp: assert property (@(posedge clk) disable iff (rst)
    q_rd_valid && q_rd_ready |=> rsp_valid)
    else $error("popped command produced no status item");

  // success always comes with the acknowledge and SW2_NONE
  a_ok_acked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status_one == ST_OK |-> rsp.acknowledged && rsp.status_two == SW2_NONE)
    else $error("ok status without acknowledge");

  // rejected class, refused or wrong-length command is never acknowledged
  a_reject_no_ack: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status_one == ST_BAD_CLASS || rsp.status_one == ST_REFUSED ||
                  rsp.status_one == ST_LENGTH) |-> !rsp.acknowledged)
    else $error("rejected command acknowledged");

endmodule

FILE: tb/tb.sv
// Testbench for card_pin_puk_guard_unit: directed and random command items with a
// cycle-free predictor of the PIN/PUK guard checked against every status item.
// Depends on cpg_pkg and the card_pin_puk_guard_unit RTL.
module tb;
  import cpg_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;
  localparam int RUN_ITEMS   = 190;

  // Predicts the status of each accepted command and checks the returned items
  class card_guard_model;
    phase_t           phase;
    logic [3:0]       tries;
    logic [3:0]       limit;
    logic [PIN_W-1:0] pin;
    logic [PUK_W-1:0] puk;
    logic             verified;
    rsp_item_t        due_status[$];
    int               errors;

    function new();
      phase    = PHASE_BLANK;
      tries    = TRIES_RESET;
      limit    = TRIES_RESET;
      pin      = '0;
      puk      = '0;
      verified = 1'b0;
      errors   = 0;
    endfunction

    function void set_limit(logic [3:0] value);
      limit = value;
    endfunction

    function int pending();
      return due_status.size();
    endfunction

    // work out the status of one command and update the card state
    function void note_command(cmd_item_t c);
      rsp_item_t        r;
      logic [PIN_W-1:0] head_pin;
      logic [PIN_W-1:0] next_pin;
      logic [3:0]       left;
      r.status_one   = ST_REFUSED;
      r.status_two   = SW2_NONE;
      r.acknowledged = 1'b0;
      head_pin = c.payload[PAY_W-1 -: PIN_W];
      next_pin = c.payload[PAY_W-PIN_W-1 -: PIN_W];
      if (c.class_byte != CLASS_CARD) begin
        r.status_one = ST_BAD_CLASS;
      end else begin
        case (c.instruction)
          INS_INSTALL: begin
            if (phase != PHASE_BLANK) begin
              r.status_one = ST_REFUSED;
            end else if (c.length != LEN_PUK) begin
              r.status_one = ST_LENGTH;
              r.status_two = LEN_PUK;
            end else begin
              r.acknowledged = 1'b1;
              r.status_one   = ST_OK;
              puk   = c.payload[PAY_W-1 -: PUK_W];
              pin   = '0;
              phase = PHASE_PIN;
            end
          end
          INS_VERIFY: begin
            if (phase != PHASE_PIN || verified) begin
              r.status_one = ST_REFUSED;
            end else if (c.length != LEN_PIN) begin
              r.status_one = ST_LENGTH;
              r.status_two = LEN_PIN;
            end else begin
              r.acknowledged = 1'b1;
              if (head_pin != pin) begin
                // wrong PIN: count down, stay at zero, block when none left
                left  = (tries != 4'd0) ? tries - 4'd1 : 4'd0;
                tries = left;
                r.status_one = ST_SECURITY;
                r.status_two = SW2_TRIES + {4'd0, left};
                if (left == 4'd0) begin
                  phase        = PHASE_BLOCKED;
                  r.status_two = SW2_BLOCKED;
                end
              end else begin
                tries        = limit;
                verified     = 1'b1;
                r.status_one = ST_OK;
              end
            end
          end
          INS_CHANGE: begin
            if (!verified || phase == PHASE_BLOCKED) begin
              r.status_one = ST_REFUSED;
            end else if (c.length != LEN_CHANGE) begin
              r.status_one = ST_LENGTH;
              r.status_two = LEN_CHANGE;
            end else begin
              r.acknowledged = 1'b1;
              if (head_pin != pin) begin
                r.status_one = ST_SECURITY;
                r.status_two = SW2_BAD_OLD;
              end else begin
                pin          = next_pin;
                phase        = PHASE_PIN;
                r.status_one = ST_OK;
              end
            end
          end
          INS_UNBLOCK: begin
            if (phase != PHASE_BLOCKED) begin
              r.status_one = ST_REFUSED;
            end else if (c.length != LEN_PUK) begin
              r.status_one = ST_LENGTH;
              r.status_two = LEN_PUK;
            end else begin
              r.acknowledged = 1'b1;
              if (c.payload[PAY_W-1 -: PUK_W] != puk) begin
                r.status_one = ST_SECURITY;
                r.status_two = SW2_BLOCKED;
              end else begin
                tries        = limit;
                pin          = '0;
                phase        = PHASE_PIN;
                r.status_one = ST_OK;
              end
            end
          end
          default: r.status_one = ST_REFUSED;
        endcase
      end
      due_status.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // compare one returned status item with the oldest prediction
    task check_status(rsp_item_t got);
      rsp_item_t want;
      if (due_status.size() == 0) begin
        report_mismatch($sformatf("status item %h with none expected", got));
      end else begin
        want = due_status.pop_front();
        if (got.status_one != want.status_one)
          report_mismatch($sformatf("status_one %h, expected %h",
                                    got.status_one, want.status_one));
        if (got.status_two != want.status_two)
          report_mismatch($sformatf("status_two %h, expected %h",
                                    got.status_two, want.status_two));
        if (got.acknowledged != want.acknowledged)
          report_mismatch($sformatf("acknowledged %b, expected %b",
                                    got.acknowledged, want.acknowledged));
      end
    endtask
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  cmd_item_t  cmd = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_item_t  rsp;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;

  logic       hold_go = 1'b0;
  int         hold_left = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;

  card_guard_model sb = new();

  card_pin_puk_guard_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // status side: check accepted items, random stalls, one long hold on request
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_status(rsp);
    if (hold_go) begin
      hold_go   <= 1'b0;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog: too long without any item moving
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic cmd_item_t pack_cmd(logic [7:0] cls, logic [7:0] ins,
                                         logic [7:0] len, logic [PAY_W-1:0] pay);
    cmd_item_t c;
    c.class_byte  = cls;
    c.instruction = ins;
    c.length      = len;
    c.payload     = pay;
    return c;
  endfunction

  function automatic logic [PAY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // random command: mostly the well-formed next step for the card state, some noise
  function automatic cmd_item_t next_command(bit allow_unlock);
    cmd_item_t        c;
    logic [PIN_W-1:0] guess;
    logic [7:0]       pick;
    c = pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, rand_word());
    if ($urandom_range(99) < 18) begin
      if ($urandom_range(3) == 0) c.class_byte = 8'($urandom);
      case ($urandom_range(4))
        0: pick = INS_INSTALL;
        1: pick = INS_VERIFY;
        2: pick = INS_CHANGE;
        3: pick = INS_UNBLOCK;
        default: pick = 8'($urandom);
      endcase
      c.instruction = pick;
      c.length = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(9));
    end else begin
      case (sb.phase)
        PHASE_BLANK: c = pack_cmd(CLASS_CARD, INS_INSTALL, LEN_PUK, rand_word());
        PHASE_BLOCKED: begin
          c = pack_cmd(CLASS_CARD, INS_UNBLOCK, LEN_PUK, sb.puk);
          if ($urandom_range(99) < 55) c.payload = sb.puk ^ (64'd1 << $urandom_range(63));
        end
        default: begin
          guess = sb.pin;
          if (!sb.verified) begin
            if (!(allow_unlock && $urandom_range(99) < 30))
              guess = sb.pin ^ (32'd1 << $urandom_range(31));
            c = pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, {guess, PIN_W'($urandom)});
          end else begin
            if ($urandom_range(99) < 25) guess = sb.pin ^ (32'd1 << $urandom_range(31));
            c = pack_cmd(CLASS_CARD, INS_CHANGE, LEN_CHANGE, {guess, PIN_W'($urandom)});
          end
        end
      endcase
    end
    return c;
  endfunction

  // offer one command, idling before it at random, and wait for its acceptance
  task automatic send(cmd_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.note_command(c);
  endtask

  // stop offering and let every expected status item come back
  task automatic drain();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [3:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
  endtask

  // bad class, unknown and refused commands, wrong lengths, blocking and unblocking
  task automatic run_directed();
    logic [PUK_W-1:0] key;
    key = rand_word();
    send(pack_cmd(8'h00, INS_VERIFY, LEN_PIN, '0));
    send(pack_cmd(8'hFF, INS_INSTALL, LEN_PUK, '1));
    send(pack_cmd(CLASS_CARD, 8'hFF, 8'hFF, '1));
    send(pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, '0));
    send(pack_cmd(CLASS_CARD, INS_CHANGE, LEN_CHANGE, '0));
    send(pack_cmd(CLASS_CARD, INS_UNBLOCK, LEN_PUK, '0));
    send(pack_cmd(CLASS_CARD, INS_INSTALL, 8'h00, key));
    send(pack_cmd(CLASS_CARD, INS_INSTALL, 8'hFF, key));
    send(pack_cmd(CLASS_CARD, INS_INSTALL, LEN_PUK, key));
    send(pack_cmd(CLASS_CARD, INS_INSTALL, LEN_PUK, key));
    send(pack_cmd(CLASS_CARD, INS_VERIFY, 8'h00, '0));
    send(pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, {32'h0000_0001, 32'hFFFF_FFFF}));
    send(pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, '1));
    send(pack_cmd(CLASS_CARD, INS_CHANGE, LEN_CHANGE, '0));
    send(pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, {32'h8000_0000, 32'h0}));
    send(pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, '0));
    send(pack_cmd(CLASS_CARD, INS_UNBLOCK, 8'hFF, key));
    send(pack_cmd(CLASS_CARD, INS_UNBLOCK, LEN_PUK, key ^ 64'd1));
    // zero tries granted: the next wrong PIN blocks straight away
    drain();
    write_limit(4'd0);
    send(pack_cmd(CLASS_CARD, INS_UNBLOCK, LEN_PUK, key));
    send(pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, {32'h8000_0000, 32'h0}));
    send(pack_cmd(CLASS_CARD, INS_UNBLOCK, LEN_PUK, key));
    drain();
    write_limit(4'd15);
    send(pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, '1));
    send(pack_cmd(CLASS_CARD, INS_UNBLOCK, LEN_PUK, key));
    send(pack_cmd(CLASS_CARD, INS_VERIFY, LEN_PIN, '1));
    send(pack_cmd(CLASS_CARD, INS_UNBLOCK, LEN_PUK, key));
  endtask

  task automatic run_random(logic [3:0] lim, int idle, int stall, bit unlock, bit hold);
    drain();
    write_limit(lim);
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold) hold_go <= 1'b1;
    for (int i = 0; i < RUN_ITEMS; i++) send(next_command(unlock));
  endtask

  // main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(4'd1, 0, 0, 1'b0, 1'b0);
    run_random(4'd15, 73, 0, 1'b0, 1'b0);
    run_random(4'd6, 0, 73, 1'b0, 1'b0);
    run_random(4'($urandom_range(15, 1)), 12, 12, 1'b0, 1'b0);
    run_random(4'd2, 0, 0, 1'b1, 1'b1);
    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d status items never returned", sb.pending()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
